// ===== hw/rtl/h2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2d_pkg
// Shared types, sizes and codes of the two-dimensional histogram engine.
// ----------------------------------------------------------------------------
package h2d_pkg;

  // Grid size of the count store.
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int unsigned DEPTH    = MAX_COLS * MAX_ROWS;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned AXIS_W = $clog2(MAX_DIM);
  localparam int unsigned USED_W = $clog2(MAX_DIM + 1);

  // Field widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned CUSED_W = 7;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned HIT_W   = 6;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Bin edges: origin plus size times up to MAX_DIM, kept exact.
  localparam int unsigned EDGE_W = COORD_W + $clog2(MAX_DIM) + 2;

  // Normalized read: count * NORM_SCALE / peak, quotient below 2**NORM_Q_W.
  localparam int unsigned NORM_SCALE = 255;
  localparam int unsigned NORM_Q_W   = 8;
  localparam int unsigned NUM_W      = COUNT_W + NORM_Q_W;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_X_ORIGIN   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_Y_ORIGIN   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BIN_WIDTH  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BIN_HEIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_COLS_USED  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ROWS_USED  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_NORMALIZE  = 3'd6;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [HIT_W-1:0]          read_col;
    logic [HIT_W-1:0]          read_row;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [HIT_W-1:0]   hit_col;
    logic [HIT_W-1:0]   hit_row;
    logic [COUNT_W-1:0] bin_value;
    logic [COUNT_W-1:0] peak_count;
  } result_t;

  // Number of bins in use along one axis, saturated to 1..maxv.
  function automatic logic [USED_W-1:0] clamp_used(logic [CUSED_W-1:0] v,
                                                   int unsigned maxv);
    logic [USED_W-1:0] r;
    if (v == '0) begin
      r = USED_W'(1);
    end else if (32'(v) > maxv) begin
      r = USED_W'(maxv);
    end else begin
      r = USED_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/h2d_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2d_divider
// Restoring divider that scales a count by the peak, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module h2d_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [h2d_pkg::COUNT_W-1:0]    count_i,
  input  logic [h2d_pkg::COUNT_W-1:0]    peak_i,
  output logic                           done_o,
  output logic [h2d_pkg::NORM_Q_W-1:0]   quot_o
);

  localparam int unsigned NW = h2d_pkg::NUM_W;
  localparam int unsigned QW = h2d_pkg::NORM_Q_W;
  localparam int unsigned SW = $clog2(QW);

  logic          run_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] dsr_q;
  logic [QW-1:0] quot_q;
  logic [NW:0]   diff;

  // The quotient is known to be below 2**QW since the count never exceeds the
  // peak, so the divisor starts shifted by QW-1 places.
  assign diff = {1'b0, rem_q} - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= SW'(QW - 1);
        rem_q  <= NW'(count_i) * NW'(h2d_pkg::NORM_SCALE);
        dsr_q  <= NW'(peak_i) << (QW - 1);
        quot_q <= '0;
      end else if (run_q) begin
        if (!diff[NW]) begin
          rem_q <= diff[NW-1:0];
        end
        quot_q <= {quot_q[QW-2:0], ~diff[NW]};
        dsr_q  <= dsr_q >> 1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - SW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/histogram_2d_binning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_2d_binning
// Two-dimensional histogram engine with a 64 by 64 store of 32-bit counts.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown on result_o for a single cycle with done_o high, and the
// receiver must take it then because the block cannot hold it. The block
// handles one item at a time. An add item walks the bin edges of the x axis
// and then of the y axis with one shared edge adder and comparator, one edge
// per cycle, then does a read-modify-write of the count memory (a sample
// dropped on x skips the y walk). A raw read passes through the registered
// memory read to the result. A normalized read with a non-zero peak adds
// the divider, which is started, loads the scaled count, forms the quotient
// bit by bit and hands it back. A clear item sweeps the memory one entry per
// cycle. After reset the same clearing pass runs with busy high before the
// first item is taken.
// Configuration writes are taken at any time, but should only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module histogram_2d_binning (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  h2d_pkg::item_t                 item_i,
  output logic                           done_o,
  output h2d_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [h2d_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [h2d_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned EW = h2d_pkg::EDGE_W;
  localparam int unsigned CW = h2d_pkg::COORD_W;
  localparam int unsigned ZW = h2d_pkg::SIZE_W;
  localparam int unsigned AW = h2d_pkg::ADDR_W;
  localparam int unsigned XW = h2d_pkg::AXIS_W;
  localparam int unsigned UW = h2d_pkg::USED_W;
  localparam int unsigned NW = h2d_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SETUP,
    S_SEARCH,
    S_MEMRD,
    S_UPD,
    S_RDRES,
    S_DIV
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]                x_origin_q;
  logic [CW-1:0]                y_origin_q;
  logic [ZW-1:0]                bin_width_q;
  logic [ZW-1:0]                bin_height_q;
  logic [h2d_pkg::CUSED_W-1:0]  cols_used_q;
  logic [h2d_pkg::CUSED_W-1:0]  rows_used_q;
  logic                         normalize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q   <= '0;
      y_origin_q   <= '0;
      bin_width_q  <= ZW'(65536);
      bin_height_q <= ZW'(65536);
      cols_used_q  <= h2d_pkg::CUSED_W'(64);
      rows_used_q  <= h2d_pkg::CUSED_W'(64);
      normalize_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        h2d_pkg::CFG_X_ORIGIN:   x_origin_q   <= cfg_wdata_i[CW-1:0];
        h2d_pkg::CFG_Y_ORIGIN:   y_origin_q   <= cfg_wdata_i[CW-1:0];
        h2d_pkg::CFG_BIN_WIDTH:  bin_width_q  <= cfg_wdata_i[ZW-1:0];
        h2d_pkg::CFG_BIN_HEIGHT: bin_height_q <= cfg_wdata_i[ZW-1:0];
        h2d_pkg::CFG_COLS_USED:  cols_used_q  <= cfg_wdata_i[h2d_pkg::CUSED_W-1:0];
        h2d_pkg::CFG_ROWS_USED:  rows_used_q  <= cfg_wdata_i[h2d_pkg::CUSED_W-1:0];
        h2d_pkg::CFG_NORMALIZE:  normalize_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e                state_q;
  h2d_pkg::item_t        item_q;
  logic                  axis_q;       // 0 while walking x, 1 while walking y
  logic [XW-1:0]         k_q;          // bin under test on the current axis
  logic signed [EW-1:0]  acc_q;        // upper edge of bin k_q
  logic [XW-1:0]         col_q;
  logic [XW-1:0]         row_q;
  logic [AW-1:0]         addr_q;
  logic                  rd_out_q;     // read outside the store returns zero
  logic                  clr_item_q;   // clearing pass was asked for by an item
  logic [AW-1:0]         clr_cnt_q;
  logic [NW-1:0]         peak_q;
  logic                  div_start_q;
  logic                  done_q;
  h2d_pkg::result_t      res_q;

  // --------------------------------------------------------------------------
  // Shared edge adder and comparator. In setup it forms origin + size, in the
  // walk it steps the edge by one bin size, always for the selected axis.
  // --------------------------------------------------------------------------
  logic [CW-1:0]         origin_sel;
  logic [ZW-1:0]         size_sel;
  logic signed [CW-1:0]  coord_sel;
  logic [UW-1:0]         used_sel;
  logic signed [EW-1:0]  add_a;
  logic signed [EW-1:0]  add_b;
  logic signed [EW-1:0]  edge_sum;
  logic signed [EW-1:0]  coord_ext;
  logic                  hit;
  logic                  last_bin;

  assign origin_sel = axis_q ? y_origin_q : x_origin_q;
  assign size_sel   = axis_q ? bin_height_q : bin_width_q;
  assign coord_sel  = axis_q ? item_q.y_coord : item_q.x_coord;
  assign used_sel   = axis_q ? h2d_pkg::clamp_used(rows_used_q, h2d_pkg::MAX_ROWS)
                             : h2d_pkg::clamp_used(cols_used_q, h2d_pkg::MAX_COLS);

  assign add_a     = (state_q == S_SETUP) ? {{(EW-CW){origin_sel[CW-1]}}, origin_sel}
                                          : acc_q;
  assign add_b     = {{(EW-ZW){1'b0}}, size_sel};
  assign edge_sum  = add_a + add_b;
  assign coord_ext = {{(EW-CW){coord_sel[CW-1]}}, coord_sel};
  assign hit       = (coord_ext <= acc_q);
  assign last_bin  = (UW'(k_q) == used_sel - UW'(1));

  // --------------------------------------------------------------------------
  // Count memory: one write and one registered read per cycle.
  // --------------------------------------------------------------------------
  logic [NW-1:0] mem [h2d_pkg::DEPTH];
  logic [NW-1:0] rdata_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [NW-1:0] mem_wdata;
  logic [NW-1:0] cnt_inc;
  logic [NW-1:0] rd_cnt;

  assign cnt_inc   = (rdata_q == '1) ? rdata_q : rdata_q + NW'(1);
  assign rd_cnt    = rd_out_q ? '0 : rdata_q;
  assign mem_re    = (state_q == S_MEMRD);
  assign mem_we    = (state_q == S_CLR) || (state_q == S_UPD);
  assign mem_waddr = (state_q == S_CLR) ? clr_cnt_q : addr_q;
  assign mem_wdata = (state_q == S_CLR) ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[addr_q];
    end
  end

  // --------------------------------------------------------------------------
  // Normalizing divider
  // --------------------------------------------------------------------------
  logic                          div_done;
  logic [h2d_pkg::NORM_Q_W-1:0]  div_quot;

  h2d_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .count_i (rd_cnt),
    .peak_i  (peak_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Read address for a read item; an out-of-store read returns zero. The hit
  // address is formed while the y walk finds its row in k_q.
  logic          rd_in_store;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] hit_addr;

  assign rd_in_store = (32'(item_i.read_col) < h2d_pkg::MAX_COLS) &&
                       (32'(item_i.read_row) < h2d_pkg::MAX_ROWS);
  assign rd_addr  = AW'(AW'(item_i.read_row) * AW'(h2d_pkg::MAX_COLS) +
                        AW'(item_i.read_col));
  assign hit_addr = AW'(AW'(k_q) * AW'(h2d_pkg::MAX_COLS) + AW'(col_q));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      item_q      <= '0;
      axis_q      <= 1'b0;
      k_q         <= '0;
      acc_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      rd_out_q    <= 1'b0;
      clr_item_q  <= 1'b0;
      clr_cnt_q   <= '0;
      peak_q      <= '0;
      div_start_q <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (32'(clr_cnt_q) == h2d_pkg::DEPTH - 1) begin
            clr_cnt_q <= '0;
            state_q   <= S_IDLE;
            if (clr_item_q) begin
              done_q <= 1'b1;
              res_q  <= '0;
            end
            clr_item_q <= 1'b0;
          end
        end

        S_IDLE: begin
          if (start) begin
            item_q <= item_i;
            case (item_i.operation)
              h2d_pkg::OP_ADD: begin
                axis_q  <= 1'b0;
                state_q <= S_SETUP;
              end
              h2d_pkg::OP_READ: begin
                addr_q   <= rd_addr;
                rd_out_q <= !rd_in_store;
                state_q  <= S_MEMRD;
              end
              h2d_pkg::OP_CLEAR: begin
                peak_q     <= '0;
                clr_item_q <= 1'b1;
                clr_cnt_q  <= '0;
                state_q    <= S_CLR;
              end
              default: begin
                done_q           <= 1'b1;
                res_q            <= '0;
                res_q.peak_count <= peak_q;
              end
            endcase
          end
        end

        S_SETUP: begin
          acc_q   <= edge_sum;
          k_q     <= '0;
          state_q <= S_SEARCH;
        end

        S_SEARCH: begin
          if (hit) begin
            if (!axis_q) begin
              col_q   <= k_q;
              axis_q  <= 1'b1;
              state_q <= S_SETUP;
            end else begin
              row_q    <= k_q;
              addr_q   <= hit_addr;
              rd_out_q <= 1'b0;
              state_q  <= S_MEMRD;
            end
          end else if (last_bin) begin
            // Above the last edge: the sample is dropped.
            done_q           <= 1'b1;
            res_q            <= '0;
            res_q.status     <= 1'b1;
            res_q.peak_count <= peak_q;
            state_q          <= S_IDLE;
          end else begin
            k_q   <= k_q + XW'(1);
            acc_q <= edge_sum;
          end
        end

        S_MEMRD: begin
          if (item_q.operation == h2d_pkg::OP_ADD) begin
            state_q <= S_UPD;
          end else begin
            state_q <= S_RDRES;
          end
        end

        S_UPD: begin
          done_q           <= 1'b1;
          res_q.status     <= 1'b0;
          res_q.hit_col    <= h2d_pkg::HIT_W'(col_q);
          res_q.hit_row    <= h2d_pkg::HIT_W'(row_q);
          res_q.bin_value  <= cnt_inc;
          if (cnt_inc > peak_q) begin
            peak_q           <= cnt_inc;
            res_q.peak_count <= cnt_inc;
          end else begin
            res_q.peak_count <= peak_q;
          end
          state_q <= S_IDLE;
        end

        S_RDRES: begin
          if (normalize_q && (peak_q != '0)) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end else begin
            done_q           <= 1'b1;
            res_q            <= '0;
            res_q.bin_value  <= normalize_q ? '0 : rd_cnt;
            res_q.peak_count <= peak_q;
            state_q          <= S_IDLE;
          end
        end

        S_DIV: begin
          if (div_done) begin
            done_q           <= 1'b1;
            res_q            <= '0;
            res_q.bin_value  <= NW'(div_quot);
            res_q.peak_count <= peak_q;
            state_q          <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== sim/tb_histogram_2d_binning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_2d_binning
// Self-checking testbench of the two-dimensional histogram engine.
// ----------------------------------------------------------------------------
// A short directed list opens the run: reads after reset, samples at the far
// corners of the coordinate range, samples exactly on and just past bin edges,
// dropped samples, the unused operation, normalized reads with a zero and a
// non-zero peak, a zero bin size and out-of-range bin counts. It is followed
// by several phases of random items, each under a fresh grid setting. Every
// item is run through a shadow copy of the count store, and each result
// strobe is compared field by field with the oldest outstanding result.
// ----------------------------------------------------------------------------
module tb_histogram_2d_binning;
  import h2d_pkg::*;

  // The block decodes operation 3 as a no-op; the package gives it no name.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Run shape. One phase of random items per grid setting.
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int REPORT_LIMIT    = 10;
  // The tail after the last result is set well above the longest add on a
  // full grid.
  localparam int TAIL_CYCLES     = 200;
  // Worst case: about 1500 items, each as long as an add on a full grid and
  // followed by the longest sender gap, plus some 30 clear sweeps and the
  // clearing pass after reset. The limit is several times that sum.
  localparam int CYCLE_LIMIT     = 3_000_000;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  // One grid setting, field for field as the registers hold it.
  typedef struct packed {
    logic [31:0] x_org;
    logic [31:0] y_org;
    logic [30:0] bin_w;
    logic [30:0] bin_h;
    logic [6:0]  cols;
    logic [6:0]  rows;
    logic        norm;
  } grid_cfg_t;

  // One line of the directed list: either a register write or an item. An
  // item line may carry a result written out by hand.
  typedef struct {
    logic              is_cfg;
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  data;
    item_t             item;
    logic              fixed;
    result_t           want;
  } dir_step_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_bus;
  logic             done;
  result_t          result_bus;
  logic             cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  // Shadow copy of the block's state and of its registers.
  logic [COUNT_W-1:0] shadow_counts [DEPTH];
  logic [COUNT_W-1:0] shadow_peak;
  grid_cfg_t          shadow_grid;

  // Results owed by the block, oldest first.
  result_t due_bins [$];
  int      fails;
  int      cycles;

  histogram_2d_binning DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_bus),
    .done_o      (done),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog. A run that hangs ends here.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** histogram_2d_binning: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow model of the engine.
  // --------------------------------------------------------------------------

  // Bins in use along one axis: zero acts as one, anything above the store
  // size acts as the store size.
  function automatic int axis_span(logic [6:0] v, int maxv);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // First bin whose upper edge is not below the coordinate. The edges are
  // kept in 64 bits, so they never wrap even at the extremes of origin and
  // size. Returns 0 when the coordinate is above the last edge.
  function automatic bit locate_bin(longint coord, longint origin, longint size,
                                    int used, output int bin);
    bit found;
    found = 1'b0;
    bin   = 0;
    for (int k = 0; k < used; k++) begin
      if (!found && coord <= origin + size * longint'(k + 1)) begin
        found = 1'b1;
        bin   = k;
      end
    end
    return found;
  endfunction

  // Applies one item to the shadow store and returns the result it causes.
  function automatic result_t hist_step(item_t it);
    result_t     r;
    bit          okx;
    bit          oky;
    int          c;
    int          rw;
    int          idx;
    logic [31:0] cnt;
    r = '0;
    case (it.operation)
      OP_ADD: begin
        okx = locate_bin(longint'($signed(it.x_coord)), longint'($signed(shadow_grid.x_org)),
                         longint'(shadow_grid.bin_w), axis_span(shadow_grid.cols, MAX_COLS), c);
        oky = locate_bin(longint'($signed(it.y_coord)), longint'($signed(shadow_grid.y_org)),
                         longint'(shadow_grid.bin_h), axis_span(shadow_grid.rows, MAX_ROWS), rw);
        if (okx && oky) begin
          idx = rw * MAX_COLS + c;
          // Counts saturate instead of wrapping.
          if (shadow_counts[idx] != '1) shadow_counts[idx] = shadow_counts[idx] + 1;
          if (shadow_counts[idx] > shadow_peak) shadow_peak = shadow_counts[idx];
          r.hit_col   = HIT_W'(c);
          r.hit_row   = HIT_W'(rw);
          r.bin_value = shadow_counts[idx];
        end else begin
          r.status = 1'b1;
        end
      end
      OP_READ: begin
        cnt = shadow_counts[int'(it.read_row) * MAX_COLS + int'(it.read_col)];
        if (shadow_grid.norm) begin
          // A zero peak reads as zero instead of dividing by it.
          if (shadow_peak != '0) begin
            r.bin_value = 32'((64'(cnt) * 64'(NORM_SCALE)) / 64'(shadow_peak));
          end
        end else begin
          r.bin_value = cnt;
        end
      end
      OP_CLEAR: begin
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
        shadow_peak = '0;
      end
      default: begin
      end
    endcase
    r.peak_count = shadow_peak;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Sender gap after an item: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 16));
    return int'($urandom_range(40, 200));
  endfunction

  // A coordinate along one axis. Most land inside the grid, often exactly on
  // an upper edge or one step past a lower edge; the rest fall below the
  // grid, just above its last edge, or anywhere in the 32-bit range.
  function automatic logic [31:0] gen_coord(logic [31:0] org, logic [30:0] size,
                                            logic [6:0] raw_used, int maxv);
    longint o;
    longint s;
    longint v;
    int     used;
    int     k;
    int     sel;
    o    = longint'($signed(org));
    s    = longint'(size);
    used = axis_span(raw_used, maxv);
    sel  = int'($urandom_range(0, 99));
    k    = int'($urandom_range(0, 32'(used - 1)));
    if (sel < 72) begin
      case ($urandom_range(0, 3))
        0:       v = o + s * longint'(k + 1);
        1:       v = o + s * longint'(k) + 1;
        default: v = o + s * longint'(k) + ((s == 0) ? 0 : longint'($urandom_range(1, 32'(s))));
      endcase
    end else if (sel < 82) begin
      v = o - longint'($urandom_range(0, 32'h7fff_ffff));
    end else if (sel < 90) begin
      v = o + s * longint'(used) + longint'($urandom_range(1, 4));
    end else begin
      v = longint'($signed($urandom));
    end
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[31:0];
  endfunction

  // Grid setting of each random phase. The fixed ones sit at the extremes:
  // the lowest and highest origins, unit and largest bin sizes, a zero bin
  // size, and bin counts of zero and above the store size.
  function automatic grid_cfg_t phase_grid(int p);
    grid_cfg_t g;
    g = '{x_org: 32'd0, y_org: 32'd0, bin_w: 31'd65536, bin_h: 31'd65536,
          cols: 7'd64, rows: 7'd64, norm: 1'b0};
    case (p)
      1: begin
        g.x_org = $urandom;
        g.y_org = $urandom;
        g.bin_w = 31'($urandom_range(1, 32'h0010_0000));
        g.bin_h = 31'($urandom_range(1, 32'h0010_0000));
        g.cols  = 7'd4;
        g.rows  = 7'd3;
        g.norm  = 1'b1;
      end
      2: begin
        g.x_org = 32'h8000_0000;
        g.y_org = 32'h8000_0000;
        g.bin_w = 31'h7fff_ffff;
        g.bin_h = 31'h7fff_ffff;
      end
      3: begin
        g.x_org = 32'h7fff_ffff;
        g.y_org = 32'h7fff_ffff;
        g.bin_w = 31'd1;
        g.bin_h = 31'd1;
        g.cols  = 7'd127;
        g.rows  = 7'd0;
        g.norm  = 1'b1;
      end
      4: begin
        g.x_org = 32'($urandom_range(0, 2000)) - 32'd1000;
        g.y_org = 32'($urandom_range(0, 2000)) - 32'd1000;
        g.bin_w = 31'd0;
        g.bin_h = 31'($urandom_range(1, 1000));
        g.cols  = 7'd2;
        g.norm  = 1'b1;
      end
      5: begin
        g.x_org = $urandom;
        g.y_org = $urandom;
        g.bin_w = 31'($urandom_range(1, 32'h0100_0000));
        g.bin_h = 31'($urandom_range(1, 32'h0100_0000));
        g.cols  = 7'($urandom_range(1, 64));
        g.rows  = 7'($urandom_range(1, 64));
        g.norm  = 1'($urandom);
      end
      6: begin
        g.y_org = -32'sd32;
        g.bin_w = 31'd1;
        g.bin_h = 31'd1;
        g.norm  = 1'b1;
      end
      7: begin
        g.x_org = $urandom;
        g.y_org = $urandom;
        g.bin_w = 31'($urandom);
        g.bin_h = 31'($urandom);
        g.cols  = 7'($urandom);
        g.rows  = 7'($urandom);
        g.norm  = 1'($urandom);
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  function automatic dir_step_t step_item(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                          logic [5:0] c, logic [5:0] r);
    dir_step_t s;
    s = '{is_cfg: 1'b0, idx: '0, data: '0, item: '0, fixed: 1'b0, want: '0};
    s.item = '{operation: op, x_coord: x, y_coord: y, read_col: c, read_row: r};
    return s;
  endfunction

  function automatic dir_step_t step_fixed(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                           logic [5:0] c, logic [5:0] r, logic st,
                                           logic [5:0] hc, logic [5:0] hr,
                                           logic [31:0] val, logic [31:0] pk);
    dir_step_t s;
    s = step_item(op, x, y, c, r);
    s.fixed = 1'b1;
    s.want  = '{status: st, hit_col: hc, hit_row: hr, bin_value: val, peak_count: pk};
    return s;
  endfunction

  function automatic dir_step_t step_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    dir_step_t s;
    s = '{is_cfg: 1'b1, idx: idx, data: data, item: '0, fixed: 1'b0, want: '0};
    return s;
  endfunction

  // Presents one item and holds it until the block takes it. The shadow
  // store is advanced at the accepting edge. A start that stays high for the
  // next item is left alone; it is lowered only when a gap follows.
  task automatic send_item(item_t it, logic use_fixed, result_t fixed_res, int gap);
    result_t r;
    item_bus <= it;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
    r = hist_step(it);
    if (use_fixed) r = fixed_res;
    due_bins.push_back(r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every owed result has come and the block has
  // gone idle. The check runs on the falling edge so that it never races the
  // checker's pop at the rising edge.
  task automatic wait_results_done();
    if (start) start <= 1'b0;
    do @(negedge clk_i); while (due_bins.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  // Writes one register. The caller lowers the write enable after the last
  // write of a burst, so a burst keeps it high without a glitch.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_X_ORIGIN:   shadow_grid.x_org = data;
      CFG_Y_ORIGIN:   shadow_grid.y_org = data;
      CFG_BIN_WIDTH:  shadow_grid.bin_w = data[30:0];
      CFG_BIN_HEIGHT: shadow_grid.bin_h = data[30:0];
      CFG_COLS_USED:  shadow_grid.cols  = data[6:0];
      CFG_ROWS_USED:  shadow_grid.rows  = data[6:0];
      CFG_NORMALIZE:  shadow_grid.norm  = data[0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_grid(grid_cfg_t g);
    write_reg(CFG_X_ORIGIN,   g.x_org);
    write_reg(CFG_Y_ORIGIN,   g.y_org);
    write_reg(CFG_BIN_WIDTH,  {1'b0, g.bin_w});
    write_reg(CFG_BIN_HEIGHT, {1'b0, g.bin_h});
    write_reg(CFG_COLS_USED,  {25'd0, g.cols});
    write_reg(CFG_ROWS_USED,  {25'd0, g.rows});
    write_reg(CFG_NORMALIZE,  {31'd0, g.norm});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker. The block cannot hold a result back, so each strobe is
  // taken as it comes and matched against the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && done) begin
      if (due_bins.size() == 0) begin
        fails = fails + 1;
        if (fails <= REPORT_LIMIT) begin
          $display("[%0t] result strobe with no item outstanding: value %0d peak %0d",
                   $realtime, result_bus.bin_value, result_bus.peak_count);
        end
      end else begin
        w = due_bins.pop_front();
        if (result_bus.status !== w.status || result_bus.hit_col !== w.hit_col ||
            result_bus.hit_row !== w.hit_row || result_bus.bin_value !== w.bin_value ||
            result_bus.peak_count !== w.peak_count) begin
          fails = fails + 1;
          if (fails <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: want st %0d col %0d row %0d value %0d peak %0d",
                     $realtime, w.status, w.hit_col, w.hit_row, w.bin_value, w.peak_count);
            $display("              got  st %0d col %0d row %0d value %0d peak %0d",
                     result_bus.status, result_bus.hit_col, result_bus.hit_row,
                     result_bus.bin_value, result_bus.peak_count);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    dir_step_t dsteps [$];
    item_t     it;
    grid_cfg_t g;
    int        sel;
    int        gap;
    logic      burst;

    fails       = 0;
    cycles      = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_bus    <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_wdata   <= '0;
    foreach (shadow_counts[i]) shadow_counts[i] = '0;
    shadow_peak = '0;
    shadow_grid = '{x_org: 32'd0, y_org: 32'd0, bin_w: 31'd65536, bin_h: 31'd65536,
                    cols: 7'd64, rows: 7'd64, norm: 1'b0};

    // Directed list. The reset grid has unit bins from 0 to 64.0 on both
    // axes, so its last edge is 0x400000. Hand-written results are given
    // only where they are plain from the grid.
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dsteps.push_back(step_fixed(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    dsteps.push_back(step_fixed(OP_ADD, 32'h8000_0000, 32'h8000_0000, 0, 0,
                                0, 0, 0, 2, 2));
    dsteps.push_back(step_fixed(OP_ADD, 32'h7fff_ffff, 0, 0, 0, 1, 0, 0, 0, 2));
    dsteps.push_back(step_fixed(OP_ADD, 0, 32'h7fff_ffff, 0, 0, 1, 0, 0, 0, 2));
    // Exactly on the last edge of both axes: the far corner bin.
    dsteps.push_back(step_fixed(OP_ADD, 32'h0040_0000, 32'h0040_0000, 0, 0,
                                0, 63, 63, 1, 2));
    // One step past the last edge is dropped.
    dsteps.push_back(step_fixed(OP_ADD, 32'h0040_0001, 0, 0, 0, 1, 0, 0, 0, 2));
    dsteps.push_back(step_item(OP_ADD, 32'h0001_0000, 32'h0001_0001, 6'h3f, 6'h3f));
    dsteps.push_back(step_fixed(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 6'h3f, 6'h3f,
                                0, 0, 0, 0, 2));
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2, 2));
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 63, 63, 0, 0, 0, 1, 2));
    dsteps.push_back(step_cfg(CFG_NORMALIZE, 32'd1));
    // The peak bin itself scales to full range.
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 0, 0, 0, 0, 0, 255, 2));
    dsteps.push_back(step_item(OP_READ, 0, 0, 63, 63));
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 5, 5, 0, 0, 0, 0, 2));
    dsteps.push_back(step_fixed(OP_CLEAR, 32'hffff_ffff, 0, 6'h2a, 6'h15, 0, 0, 0, 0, 0));
    // Normalized read with a zero peak.
    dsteps.push_back(step_fixed(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Zero column width, zero columns in use (acts as one), rows above the
    // store size, and origins at both ends of the range.
    dsteps.push_back(step_cfg(CFG_X_ORIGIN, 32'h8000_0000));
    dsteps.push_back(step_cfg(CFG_Y_ORIGIN, 32'h7fff_ffff));
    dsteps.push_back(step_cfg(CFG_BIN_WIDTH, 32'd0));
    dsteps.push_back(step_cfg(CFG_BIN_HEIGHT, 32'h7fff_ffff));
    dsteps.push_back(step_cfg(CFG_COLS_USED, 32'd0));
    dsteps.push_back(step_cfg(CFG_ROWS_USED, 32'd127));
    dsteps.push_back(step_item(OP_ADD, 0, 0, 0, 0));
    dsteps.push_back(step_item(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    dsteps.push_back(step_item(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    dsteps.push_back(step_cfg(CFG_NORMALIZE, 32'd0));
    dsteps.push_back(step_item(OP_READ, 0, 0, 0, 0));

    // Reset once. The block then clears its store with busy high, and the
    // first item simply waits for busy to drop.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dsteps[i]) begin
      if (dsteps[i].is_cfg) begin
        if (i == 0 || !dsteps[i - 1].is_cfg) wait_results_done();
        write_reg(dsteps[i].idx, dsteps[i].data);
        if (i == dsteps.size() - 1 || !dsteps[i + 1].is_cfg) cfg_we <= 1'b0;
      end else begin
        send_item(dsteps[i].item, dsteps[i].fixed, dsteps[i].want, idle_gap());
      end
    end

    // Random phases. Each one starts from an idle block with a new grid.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_done();
      g = phase_grid(p);
      apply_grid(g);
      burst = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then switch between idling and back-to-back items.
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        // Occasionally let the block run dry before the next item.
        if ($urandom_range(0, 99) == 0) wait_results_done();
        // Fields that the operation ignores still carry random bits.
        it.x_coord  = $urandom;
        it.y_coord  = $urandom;
        it.read_col = 6'($urandom);
        it.read_row = 6'($urandom);
        sel = int'($urandom_range(0, 999));
        if (sel < 650) begin
          it.operation = OP_ADD;
          it.x_coord   = gen_coord(g.x_org, g.bin_w, g.cols, MAX_COLS);
          it.y_coord   = gen_coord(g.y_org, g.bin_h, g.rows, MAX_ROWS);
        end else if (sel < 950) begin
          it.operation = OP_READ;
          // Mostly bins inside the used grid, where the counts are.
          if ($urandom_range(0, 9) < 6) begin
            it.read_col = 6'($urandom_range(0, 32'(axis_span(g.cols, MAX_COLS) - 1)));
            it.read_row = 6'($urandom_range(0, 32'(axis_span(g.rows, MAX_ROWS) - 1)));
          end
        end else if (sel < 965) begin
          it.operation = OP_CLEAR;
        end else begin
          it.operation = OP_UNUSED;
        end
        gap = burst ? 0 : idle_gap();
        send_item(it, 1'b0, '0, gap);
      end
    end

    // Drain, then give the block time to show any stray strobe.
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_bins.size() != 0) begin
      fails = fails + 1;
      $display("%0d results never arrived", due_bins.size());
    end

    if (fails == 0) begin
      $display("** histogram_2d_binning: PASSED **");
    end else begin
      $display("** histogram_2d_binning: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/h2d_pkg.sv
hw/rtl/h2d_divider.sv
hw/rtl/histogram_2d_binning.sv
sim/tb_histogram_2d_binning.sv
